>>> src/rdcr_pkg.sv
// Shared types, constants and helper functions for the remote drive command ramp.
// No dependencies; imported by remote_drive_command_ramp, rdcr_cfg and rdcr_core.
`timescale 1ns / 1ps

package rdcr_pkg;

	localparam int APB_AW = 5;
	localparam int APB_DW = 32;

	// Turn scaling: q = (mag * sens * DIV_RECIP) >> DIV_SHIFT equals (mag * sens) / 100
	// for every product up to 100 * 100.
	localparam int           DIV_SHIFT = 19;
	localparam int           TURN_K_W  = 20;
	localparam int           TURN_P_W  = 26;
	localparam logic [12:0]  DIV_RECIP = 13'd5243;

	localparam logic [6:0]   PCT_LIMIT = 7'd100;

	localparam logic [7:0] CMD_F = 8'h46;
	localparam logic [7:0] CMD_B = 8'h42;
	localparam logic [7:0] CMD_L = 8'h4C;
	localparam logic [7:0] CMD_R = 8'h52;
	localparam logic [7:0] CMD_U = 8'h55;
	localparam logic [7:0] CMD_W = 8'h57;
	localparam logic [7:0] CMD_X = 8'h58;
	localparam logic [7:0] CMD_Y = 8'h59;
	localparam logic [7:0] CMD_Z = 8'h5A;

	localparam logic MODE_TICK = 1'b1;

	typedef enum logic [2:0] {
		REG_BASE    = 3'd0,
		REG_MAX     = 3'd1,
		REG_STEP    = 3'd2,
		REG_SENS    = 3'd3,
		REG_TIMEOUT = 3'd4
	} reg_idx_t;

	typedef struct packed {
		logic [6:0]          base_speed;
		logic [6:0]          max_speed;
		logic [6:0]          speed_step;
		logic [TURN_K_W-1:0] turn_k;
		logic [15:0]         timeout_ticks;
	} rdcr_cfg_t;

	typedef struct packed {
		logic signed [7:0] straight_speed;
		logic signed [7:0] turn_speed;
		logic              drive_update;
		logic              moving;
		logic [7:0]        last_command;
	} rdcr_res_t;

	// Clamp a 7-bit percent write to 100.
	function automatic logic [6:0] pct_sat(input logic [6:0] v);
		return (v > PCT_LIMIT) ? PCT_LIMIT : v;
	endfunction

	// Ramp a signed target up or down: base on first press or reversal, else add step and clamp.
	function automatic logic signed [7:0] ramp(
		input logic signed [7:0] cur,
		input logic              up,
		input logic              changed,
		input logic [6:0]        base_v,
		input logic [6:0]        max_v,
		input logic [6:0]        step_v
	);
		logic signed [8:0] sum_up;
		logic signed [8:0] sum_dn;
		logic signed [8:0] lim;
		logic signed [7:0] res;
		sum_up = $signed({cur[7], cur}) + $signed({2'b00, step_v});
		sum_dn = $signed({cur[7], cur}) - $signed({2'b00, step_v});
		lim    = $signed({2'b00, max_v});
		if (up) begin
			if (changed || cur <= 8'sd0)
				res = $signed({1'b0, base_v});
			else if (sum_up > lim)
				res = $signed({1'b0, max_v});
			else
				res = $signed(sum_up[7:0]);
		end else begin
			if (changed || cur >= 8'sd0)
				res = -$signed({1'b0, base_v});
			else if (sum_dn < -lim)
				res = -$signed({1'b0, max_v});
			else
				res = $signed(sum_dn[7:0]);
		end
		return res;
	endfunction

endpackage

>>> src/rdcr_if.sv
// Valid/ready stream interfaces for command beats in and drive result beats out.
// Depends on nothing.
`timescale 1ns / 1ps

interface rdcr_in_if;
	logic       valid;
	logic       ready;
	logic       mode;
	logic [7:0] cmd_byte;

	modport source (output valid, mode, cmd_byte, input ready);
	modport sink   (input valid, mode, cmd_byte, output ready);
endinterface

interface rdcr_out_if;
	logic              valid;
	logic              ready;
	logic signed [7:0] straight_speed;
	logic signed [7:0] turn_speed;
	logic              drive_update;
	logic              moving;
	logic [7:0]        last_command;

	modport source (output valid, straight_speed, turn_speed, drive_update, moving,
		last_command, input ready);
	modport sink   (input valid, straight_speed, turn_speed, drive_update, moving,
		last_command, output ready);
endinterface

>>> src/remote_drive_command_ramp.sv
// Remote drive command ramp: an accepted beat passes the input register, then a single-pass
// update into the result register sets its result beat valid. Throughput one beat per cycle
// unless res_ch stalls; drive state updates in the cycle a beat leaves the input register.
// Reset (arst_n low, asynchronous) clears targets, moving flag, last command and idle
// count, empties both pipeline registers, and loads settings 30, 100, 10, 50 and 800.
// Depends on rdcr_pkg, rdcr_in_if/rdcr_out_if, rdcr_cfg and rdcr_core.
`timescale 1ns / 1ps

module remote_drive_command_ramp import rdcr_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready,
	rdcr_in_if.sink           cmd_ch,
	rdcr_out_if.source        res_ch
);

	rdcr_cfg_t  cfg;
	rdcr_res_t  res;

	// Input register stage.
	logic       valid_s1;
	logic       mode_s1;
	logic [7:0] cmd_s1;

	// Result register.
	logic       out_valid_q;
	rdcr_res_t  out_q;

	logic       advance;
	logic       step;
	logic       in_fire;

	// Advance whenever the result register is empty or being drained this cycle.
	assign advance      = !out_valid_q || res_ch.ready;
	assign cmd_ch.ready = !valid_s1 || advance;
	assign in_fire      = cmd_ch.valid && cmd_ch.ready;
	// The beat in the input register is processed and its state committed.
	assign step         = valid_s1 && advance;

	rdcr_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	rdcr_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (step),
		.mode     (mode_s1),
		.cmd_byte (cmd_s1),
		.cfg      (cfg),
		.res      (res)
	);

	// Load a new beat, or drop the stage once its beat has moved on.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_fire) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			mode_s1 <= cmd_ch.mode;
			cmd_s1  <= cmd_ch.cmd_byte;
		end
	end

	// Hold the result until it is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			out_q <= res;
		end
	end

	assign res_ch.valid          = out_valid_q;
	assign res_ch.straight_speed = out_q.straight_speed;
	assign res_ch.turn_speed     = out_q.turn_speed;
	assign res_ch.drive_update   = out_q.drive_update;
	assign res_ch.moving         = out_q.moving;
	assign res_ch.last_command   = out_q.last_command;

endmodule

>>> src/rdcr_cfg.sv
// APB register file for the ramp settings; also holds the precomputed turn scale.
// Depends on rdcr_pkg.
`timescale 1ns / 1ps

module rdcr_cfg import rdcr_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready,
	output rdcr_cfg_t         cfg
);

	logic [6:0]          base_q;
	logic [6:0]          max_q;
	logic [6:0]          step_q;
	logic [6:0]          sens_q;
	logic [TURN_K_W-1:0] turn_k_q;
	logic [15:0]         timeout_q;
	logic                wr_en;
	reg_idx_t            idx;
	logic [6:0]          wr_pct;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;
	assign idx    = reg_idx_t'(paddr[APB_AW-1:2]);
	assign wr_pct = pct_sat(pwdata[6:0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q    <= 7'd30;
			max_q     <= 7'd100;
			step_q    <= 7'd10;
			sens_q    <= 7'd50;
			turn_k_q  <= TURN_K_W'(50 * 5243);
			timeout_q <= 16'd800;
		end else if (wr_en) begin
			case (idx)
				REG_BASE:    base_q <= wr_pct;
				REG_MAX:     max_q  <= wr_pct;
				REG_STEP:    step_q <= wr_pct;
				REG_SENS: begin
					sens_q   <= wr_pct;
					turn_k_q <= TURN_K_W'(wr_pct) * TURN_K_W'(DIV_RECIP);
				end
				REG_TIMEOUT: timeout_q <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_BASE:    prdata = {25'd0, base_q};
			REG_MAX:     prdata = {25'd0, max_q};
			REG_STEP:    prdata = {25'd0, step_q};
			REG_SENS:    prdata = {25'd0, sens_q};
			REG_TIMEOUT: prdata = {16'd0, timeout_q};
			default:     prdata = '0;
		endcase
	end

	assign cfg.base_speed    = base_q;
	assign cfg.max_speed     = max_q;
	assign cfg.speed_step    = step_q;
	assign cfg.turn_k        = turn_k_q;
	assign cfg.timeout_ticks = timeout_q;

endmodule

>>> src/rdcr_core.sv
// Drive state registers and the single-pass update for one command or tick beat.
// Depends on rdcr_pkg.
`timescale 1ns / 1ps

module rdcr_core import rdcr_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  logic       mode,
	input  logic [7:0] cmd_byte,
	input  rdcr_cfg_t  cfg,
	output rdcr_res_t  res
);

	logic signed [7:0]   straight_q;
	logic signed [7:0]   turn_q;
	logic                moving_q;
	logic [7:0]          prev_q;
	logic [15:0]         elapsed_q;

	logic signed [7:0]   straight_d;
	logic signed [7:0]   turn_d;
	logic                moving_d;
	logic [7:0]          prev_d;
	logic [15:0]         elapsed_d;
	logic                upd;

	logic                changed;
	logic [15:0]         elapsed_inc;
	logic signed [7:0]   st_up;
	logic signed [7:0]   st_dn;
	logic signed [7:0]   turn_up;
	logic signed [7:0]   turn_dn;
	logic                diag_up;
	logic signed [7:0]   st_diag;
	logic [6:0]          st_mag;
	logic [TURN_P_W-1:0] turn_prod;
	logic signed [7:0]   turn_pos;
	logic signed [7:0]   turn_of;

	assign changed     = (prev_q != cmd_byte);
	assign elapsed_inc = (elapsed_q == 16'hFFFF) ? elapsed_q : elapsed_q + 16'd1;

	assign st_up   = ramp(straight_q, 1'b1, changed, cfg.base_speed, cfg.max_speed,
		cfg.speed_step);
	assign st_dn   = ramp(straight_q, 1'b0, changed, cfg.base_speed, cfg.max_speed,
		cfg.speed_step);
	assign turn_up = ramp(turn_q, 1'b1, changed, cfg.base_speed, cfg.max_speed,
		cfg.speed_step);
	assign turn_dn = ramp(turn_q, 1'b0, changed, cfg.base_speed, cfg.max_speed,
		cfg.speed_step);

	// Diagonals share one scaler: W and Y ramp forward, X and Z ramp backward.
	assign diag_up   = (cmd_byte == CMD_W) || (cmd_byte == CMD_Y);
	assign st_diag   = diag_up ? st_up : st_dn;
	assign st_mag    = st_diag[7] ? 7'(-st_diag) : st_diag[6:0];
	assign turn_prod = TURN_P_W'(st_mag) * TURN_P_W'(cfg.turn_k);
	assign turn_pos  = $signed({1'b0, turn_prod[TURN_P_W-1:DIV_SHIFT]});
	// Truncate toward zero: scale the magnitude, then restore the sign.
	assign turn_of   = st_diag[7] ? -turn_pos : turn_pos;

	always_comb begin
		straight_d = straight_q;
		turn_d     = turn_q;
		moving_d   = moving_q;
		prev_d     = prev_q;
		elapsed_d  = elapsed_q;
		upd        = 1'b0;
		if (mode == MODE_TICK) begin
			elapsed_d = elapsed_inc;
			if (moving_q && elapsed_inc >= cfg.timeout_ticks) begin
				straight_d = '0;
				turn_d     = '0;
				moving_d   = 1'b0;
				upd        = 1'b1;
			end
		end else begin
			elapsed_d = '0;
			prev_d    = cmd_byte;
			upd       = 1'b1;
			case (cmd_byte)
				CMD_F: begin
					straight_d = st_up;
					turn_d     = '0;
				end
				CMD_B: begin
					straight_d = st_dn;
					turn_d     = '0;
				end
				CMD_L: begin
					turn_d     = turn_dn;
					straight_d = '0;
				end
				CMD_R: begin
					turn_d     = turn_up;
					straight_d = '0;
				end
				CMD_U: begin
					straight_d = $signed({1'b0, cfg.max_speed});
					turn_d     = '0;
				end
				CMD_W, CMD_Z: begin
					straight_d = st_diag;
					turn_d     = -turn_of;
				end
				CMD_X, CMD_Y: begin
					straight_d = st_diag;
					turn_d     = turn_of;
				end
				default: upd = 1'b0;
			endcase
			if (upd)
				moving_d = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			straight_q <= '0;
			turn_q     <= '0;
			moving_q   <= 1'b0;
			prev_q     <= '0;
			elapsed_q  <= '0;
		end else if (step) begin
			straight_q <= straight_d;
			turn_q     <= turn_d;
			moving_q   <= moving_d;
			prev_q     <= prev_d;
			elapsed_q  <= elapsed_d;
		end
	end

	assign res.straight_speed = straight_d;
	assign res.turn_speed     = turn_d;
	assign res.drive_update   = upd;
	assign res.moving         = moving_d;
	assign res.last_command   = prev_d;

`ifndef SYNTH
	// A command byte restarts the idle count.
	a_cmd_clears_count: assert property (@(posedge clk) disable iff (!arst_n)
		step && mode != MODE_TICK |=> elapsed_q == 16'd0)
		else $error("idle count not cleared by command beat");

	// A drive update on a tick is always a timeout stop.
	a_timeout_stop: assert property (@(posedge clk) disable iff (!arst_n)
		step && mode == MODE_TICK && upd |=> straight_q == 8'sd0 && turn_q == 8'sd0 &&
		!moving_q)
		else $error("timeout stop left motion state behind");

	// Stopped means zero targets.
	a_stopped_zero: assert property (@(posedge clk) disable iff (!arst_n)
		!moving_q |-> straight_q == 8'sd0 && turn_q == 8'sd0)
		else $error("nonzero target while stopped");

	// Without a beat the state holds.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!step |=> $stable(straight_q) && $stable(turn_q) && $stable(prev_q) &&
		$stable(elapsed_q))
		else $error("drive state changed without a beat");
`endif

endmodule
